FILE: src/urde_pkg.sv
// Shared types, codes and CRC-8 helper for the register datagram engine.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package urde_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_RX    = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  // Result item kinds
  localparam logic OUT_BYTE   = 1'b0;
  localparam logic OUT_REPORT = 1'b1;

  // Read completion status
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FAILED  = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_NODE_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] CFG_MAX_TRIES     = 2'd2;

  localparam logic [7:0] RST_TIMEOUT_TICKS = 8'd5;
  localparam logic [3:0] RST_MAX_TRIES     = 4'd2;

  // Datagram framing bytes
  localparam logic [7:0] SYNC_BYTE  = 8'h05;
  localparam logic [7:0] REPLY_ADDR = 8'hFF;
  localparam logic [7:0] WRITE_FLAG = 8'h80;
  localparam logic [7:0] CRC_POLY   = 8'h07;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HUNT,
    PH_COLLECT
  } phase_t;

  typedef enum logic [1:0] {
    JOB_WRITE,
    JOB_REQUEST,
    JOB_REPORT
  } job_kind_t;

  typedef struct packed {
    logic [1:0] node_address;
    logic [7:0] timeout_ticks;
    logic [3:0] max_tries;
  } cfg_t;

  // One unit of work for the transmit side; data is write data or read value
  typedef struct packed {
    job_kind_t   kind;
    logic [1:0]  node;
    logic [6:0]  reg_addr;
    logic [31:0] data;
    logic [1:0]  status;
  } job_t;

  // CRC-8, poly 0x07, one byte taken LSB first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (c[7] ^ b[k]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Running CRC after the fixed part of a reply header (05 FF)
  localparam logic [7:0] HDR_CRC = crc8_feed(crc8_feed(8'h00, SYNC_BYTE), REPLY_ADDR);

endpackage

FILE: src/urde_fifo.sv
// Short job queue between the protocol front and the transmit back.
// Depends on urde_pkg for job_t.
`timescale 1ns / 1ps

module urde_fifo import urde_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: src/urde_front.sv
// Protocol front: classifies items, runs the read handshake (header hunt,
// reply collection, timeout, retries) and issues at most one job per item.
// Depends on urde_pkg.
`timescale 1ns / 1ps

module urde_front import urde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [1:0]  kind,
  input  logic [6:0]  reg_address,
  input  logic [31:0] write_data,
  input  logic [7:0]  rx_byte,
  input  cfg_t        cfg,
  output logic        job_push,
  output job_t        job
);

  phase_t      phase, phase_next;
  logic [23:0] window, window_next;
  logic [31:0] reply_data, reply_data_next;
  logic [7:0]  crc_run, crc_run_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  tick_left, tick_left_next;
  logic [3:0]  tries, tries_next;
  logic [6:0]  pending, pending_next;

  logic        fail;
  logic        start_req;
  logic [7:0]  load_ticks;
  logic [3:0]  try_limit;

  assign load_ticks = (cfg.timeout_ticks == 8'd0) ? 8'd1 : cfg.timeout_ticks;
  assign try_limit  = (cfg.max_tries == 4'd0) ? 4'd1 : cfg.max_tries;

  always_comb begin
    phase_next      = phase;
    window_next     = window;
    reply_data_next = reply_data;
    crc_run_next    = crc_run;
    byte_count_next = byte_count;
    tick_left_next  = tick_left;
    tries_next      = tries;
    pending_next    = pending;
    fail            = 1'b0;
    start_req       = 1'b0;
    job_push        = 1'b0;
    job.kind        = JOB_REPORT;
    job.node        = cfg.node_address;
    job.reg_addr    = reg_address;
    job.data        = '0;
    job.status      = STATUS_OK;

    if (take) begin
      case (kind)
        KIND_WRITE, KIND_READ: begin
          if (phase != PH_IDLE) begin
            job_push   = 1'b1;
            job.status = STATUS_REFUSED;
          end else if (kind == KIND_WRITE) begin
            job_push = 1'b1;
            job.kind = JOB_WRITE;
            job.data = write_data;
          end else begin
            pending_next = reg_address;
            tries_next   = 4'd1;
            start_req    = 1'b1;
          end
        end
        KIND_TICK: begin
          if (phase != PH_IDLE) begin
            if (tick_left <= 8'd1) begin
              tick_left_next = 8'd0;
              fail           = 1'b1;
            end else begin
              tick_left_next = tick_left - 8'd1;
            end
          end
        end
        KIND_RX: begin
          case (phase)
            PH_HUNT: begin
              window_next = {window[15:0], rx_byte};
              if (window_next == {SYNC_BYTE, REPLY_ADDR, 1'b0, pending}) begin
                phase_next      = PH_COLLECT;
                byte_count_next = 3'd0;
                crc_run_next    = crc8_feed(HDR_CRC, {1'b0, pending});
                tick_left_next  = load_ticks;
              end
            end
            PH_COLLECT: begin
              if (byte_count == 3'd4) begin
                // fifth byte is the CRC of the reply
                byte_count_next = 3'd0;
                if (crc_run == rx_byte && crc_run != 8'd0) begin
                  phase_next = PH_IDLE;
                  job_push   = 1'b1;
                  job.data   = reply_data;
                  job.status = STATUS_OK;
                end else begin
                  fail = 1'b1;
                end
              end else begin
                reply_data_next = {reply_data[23:0], rx_byte};
                crc_run_next    = crc8_feed(crc_run, rx_byte);
                byte_count_next = byte_count + 3'd1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    if (fail) begin
      if (tries < try_limit) begin
        tries_next = tries + 4'd1;
        start_req  = 1'b1;
      end else begin
        phase_next = PH_IDLE;
        job_push   = 1'b1;
        job.status = STATUS_FAILED;
      end
    end

    if (start_req) begin
      phase_next      = PH_HUNT;
      window_next     = '0;
      byte_count_next = 3'd0;
      tick_left_next  = load_ticks;
      job_push        = 1'b1;
      job.kind        = JOB_REQUEST;
      job.reg_addr    = pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_count <= '0;
      tick_left  <= '0;
      tries      <= '0;
      pending    <= '0;
    end else begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      tick_left  <= tick_left_next;
      tries      <= tries_next;
      pending    <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    window     <= window_next;
    reply_data <= reply_data_next;
    crc_run    <= crc_run_next;
  end

endmodule

FILE: src/urde_back.sv
// Transmit back: turns queued jobs into result items, one byte a cycle while
// out_stall allows, the CRC accumulated as it goes out. Depends on urde_pkg.
`timescale 1ns / 1ps

module urde_back import urde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  job_t        head,
  input  logic        q_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  tx_byte,
  output logic        last_byte,
  output logic [31:0] read_value,
  output logic [1:0]  read_status
);

  logic       busy;
  job_t       cur;
  logic [2:0] idx;
  logic [7:0] crc;

  job_t       src;
  logic [2:0] sidx;
  logic [7:0] scrc;
  logic [7:0] dbyte;
  logic       is_write;
  logic       is_last;
  logic [7:0] crc_new;
  logic       load_ok;
  logic       fire;

  // continue the current datagram, otherwise start straight from the queue head
  assign src      = busy ? cur : head;
  assign sidx     = busy ? idx : 3'd0;
  assign scrc     = busy ? crc : 8'd0;
  assign is_write = (src.kind == JOB_WRITE);
  assign is_last  = is_write ? (sidx == 3'd7) : (sidx == 3'd3);
  assign load_ok  = !out_valid || !out_stall;
  assign fire     = (busy || !q_empty) && load_ok;
  assign pop      = fire && !busy;
  assign crc_new  = crc8_feed(scrc, dbyte);

  always_comb begin
    case (sidx)
      3'd0:    dbyte = SYNC_BYTE;
      3'd1:    dbyte = {6'd0, src.node};
      3'd2:    dbyte = is_write ? (WRITE_FLAG | {1'b0, src.reg_addr}) : {1'b0, src.reg_addr};
      3'd3:    dbyte = is_write ? src.data[31:24] : scrc;
      3'd4:    dbyte = src.data[23:16];
      3'd5:    dbyte = src.data[15:8];
      3'd6:    dbyte = src.data[7:0];
      default: dbyte = scrc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
      busy      <= (src.kind != JOB_REPORT) && !is_last;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur <= src;
      idx <= sidx + 3'd1;
      crc <= crc_new;
      if (src.kind == JOB_REPORT) begin
        out_kind    <= OUT_REPORT;
        tx_byte     <= 8'd0;
        last_byte   <= 1'b0;
        read_value  <= src.data;
        read_status <= src.status;
      end else begin
        out_kind    <= OUT_BYTE;
        tx_byte     <= dbyte;
        last_byte   <= is_last;
        read_value  <= '0;
        read_status <= STATUS_OK;
      end
    end
  end

endmodule

FILE: src/uart_register_datagram_engine.sv
// Top level of the register datagram engine: configuration registers, protocol
// front, job queue and transmit back. Depends on urde_pkg, urde_front,
// urde_fifo and urde_back.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+------------------------------------------
//   input    | in_valid / in_stall          | kind, reg_address, write_data, rx_byte
//   output   | out_valid / out_stall        | out_kind, tx_byte, last_byte, read_value,
//            |                              | read_status
//   config   | cfg_write, cfg_index         | cfg_data
//
// The front takes one item a cycle while in_stall is low; each item queues at most
// one job. The back emits one result item a cycle while not held by out_stall: a
// write job is 8 bytes, a read request 4, a report 1. in_stall rises only when the
// job queue is full. Output is registered; out_stall holds the current item and
// lets the queue fill. Reset (rst, synchronous) returns to idle with an empty queue.
`timescale 1ns / 1ps

module uart_register_datagram_engine import urde_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [6:0]  reg_address,
  input  logic [31:0] write_data,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  tx_byte,
  output logic        last_byte,
  output logic [31:0] read_value,
  output logic [1:0]  read_status
);

  cfg_t cfg;
  logic take;
  logic job_push;
  job_t job;
  job_t head;
  logic q_empty;
  logic q_full;
  logic pop;

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_address  <= '0;
      cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
      cfg.max_tries     <= RST_MAX_TRIES;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NODE_ADDRESS:  cfg.node_address  <= cfg_data[1:0];
        CFG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        CFG_MAX_TRIES:     cfg.max_tries     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  urde_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .kind        (kind),
    .reg_address (reg_address),
    .write_data  (write_data),
    .rx_byte     (rx_byte),
    .cfg         (cfg),
    .job_push    (job_push),
    .job         (job)
  );

  urde_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  urde_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .tx_byte     (tx_byte),
    .last_byte   (last_byte),
    .read_value  (read_value),
    .read_status (read_status)
  );

endmodule
